### hdl/sst_pkg.sv
package sst_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int COUNT_BITS  = 16;
  localparam int KIND_BITS   = 6;
  localparam int NUM_KW      = 13;
  localparam int KW_BYTES    = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // token kinds
  localparam logic [KIND_BITS-1:0] K_IDENT   = 6'd13;
  localparam logic [KIND_BITS-1:0] K_END     = 6'd14;
  localparam logic [KIND_BITS-1:0] K_NEWLINE = 6'd15;
  localparam logic [KIND_BITS-1:0] K_NUMBER  = 6'd16;
  localparam logic [KIND_BITS-1:0] K_LPAREN  = 6'd17;
  localparam logic [KIND_BITS-1:0] K_RPAREN  = 6'd18;
  localparam logic [KIND_BITS-1:0] K_LBRACE  = 6'd19;
  localparam logic [KIND_BITS-1:0] K_RBRACE  = 6'd20;
  localparam logic [KIND_BITS-1:0] K_LBRACK  = 6'd21;
  localparam logic [KIND_BITS-1:0] K_RBRACK  = 6'd22;
  localparam logic [KIND_BITS-1:0] K_COMMA   = 6'd23;
  localparam logic [KIND_BITS-1:0] K_DOTDOT  = 6'd24;
  localparam logic [KIND_BITS-1:0] K_PLUS    = 6'd25;
  localparam logic [KIND_BITS-1:0] K_MINUS   = 6'd26;
  localparam logic [KIND_BITS-1:0] K_STAR    = 6'd27;
  localparam logic [KIND_BITS-1:0] K_SLASH   = 6'd28;
  localparam logic [KIND_BITS-1:0] K_PERCENT = 6'd29;
  localparam logic [KIND_BITS-1:0] K_EQEQ    = 6'd30;
  localparam logic [KIND_BITS-1:0] K_EQ      = 6'd31;
  localparam logic [KIND_BITS-1:0] K_NE      = 6'd32;
  localparam logic [KIND_BITS-1:0] K_BANG    = 6'd33;
  localparam logic [KIND_BITS-1:0] K_LE      = 6'd34;
  localparam logic [KIND_BITS-1:0] K_LT      = 6'd35;
  localparam logic [KIND_BITS-1:0] K_GE      = 6'd36;
  localparam logic [KIND_BITS-1:0] K_GT      = 6'd37;
  localparam logic [KIND_BITS-1:0] K_ANDAND  = 6'd38;
  localparam logic [KIND_BITS-1:0] K_OROR    = 6'd39;
  localparam logic [KIND_BITS-1:0] K_INVALID = 6'd40;

  // keyword text, first byte lowest; index equals token kind
  localparam logic [8*KW_BYTES-1:0] KW_TEXT [NUM_KW] = '{
    48'h000000006669, 48'h00000074656C, 48'h000000726176, 48'h000065707974,
    48'h000065736C65, 48'h00000079656B, 48'h000000006E69, 48'h000000726F66,
    48'h000074696E69, 48'h6C61626F6C67, 48'h7265646E6572, 48'h00726F6C6F63,
    48'h657461647075
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd3, 3'd2, 3'd3, 3'd4, 3'd6, 3'd6, 3'd5, 3'd6
  };

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [OFFSET_BITS-1:0] start;
    logic [COUNT_BITS-1:0]  len;
    logic [COUNT_BITS-1:0]  line;
    logic [COUNT_BITS-1:0]  col;
  } tok_t;

  typedef struct packed {
    tok_t tok;
    logic last;
  } qent_t;

  typedef struct packed {
    logic [QCNT_BITS-1:0] count;
    logic                 room;
  } qstat_t;

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_ident_cont(logic [7:0] b);
    return is_alpha(b) || is_digit(b) || b == 8'h5F;
  endfunction

  // keyword lookup over the first six bytes and the length
  function automatic logic [KIND_BITS-1:0] ident_kind(logic [8*KW_BYTES-1:0] chars,
                                                     logic [COUNT_BITS-1:0] len);
    logic [KIND_BITS-1:0] k;
    k = K_IDENT;
    if (len <= COUNT_BITS'(KW_BYTES)) begin
      for (int i = NUM_KW - 1; i >= 0; i--) begin
        if (len == COUNT_BITS'(KW_LEN[i]) && chars == KW_TEXT[i]) k = KIND_BITS'(i);
      end
    end
    return k;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] x);
    return (&x) ? x : x + 1'b1;
  endfunction

endpackage

### hdl/script_source_tokenizer.sv
// channel | dir | handshake          | payload
// in      | in  | in_tvalid/tready   | in_tdata: source byte, 0 ends the source
// out     | out | out_tvalid/tready  | out_tdata: token fields, out_tlast: last of byte
// one byte is taken per cycle; each byte releases zero, one or two tokens
// tokens wait in a four-entry queue; a byte is taken while two slots are free
// a stalled output holds the queue and, once it fills, the input
// synchronous active-low reset zeroes position, sets line and column to 1, clears lookahead
// the end token (byte 0) returns all counters to their reset values
module script_source_tokenizer
  import sst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [5:0] token_kind, [29:6] start_offset,
                                  // [45:30] token_length, [61:46] line_number,
                                  // [77:62] column_number, [79:78] zero
  output logic        out_tlast   // last_of_run
);

  typedef enum logic [10:0] {
    M_IDLE   = 11'b00000000001,
    M_IDENT  = 11'b00000000010,
    M_NUM    = 11'b00000000100,
    M_NUMDOT = 11'b00000001000,
    M_DOT    = 11'b00000010000,
    M_EQ     = 11'b00000100000,
    M_BANG   = 11'b00001000000,
    M_LT     = 11'b00010000000,
    M_GT     = 11'b00100000000,
    M_AMP    = 11'b01000000000,
    M_PIPE   = 11'b10000000000
  } mode_t;

  typedef enum logic [1:0] {R_NORMAL, R_NEWLINE, R_END} res_t;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
  localparam logic [COUNT_BITS-1:0]  CNT_MAX = '1;

  mode_t                   mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0]  pos_r, pos_nxt, tstart_r, tstart_nxt;
  logic [COUNT_BITS-1:0]   line_r, line_nxt, col_r, col_nxt;
  logic [COUNT_BITS-1:0]   tlen_r, tlen_nxt, tline_r, tline_nxt, tcol_r, tcol_nxt;
  logic [8*KW_BYTES-1:0]   kw_r, kw_nxt;

  logic [7:0] b;
  logic       acc;
  qstat_t     qstat;
  qent_t      q_rd;

  assign b   = in_tdata;
  assign acc = in_tvalid && in_tready;

  // fresh token start for the current byte
  mode_t                f_mode;
  logic                 f_emit, f_ident;
  tok_t                 f_tok;
  res_t                 f_res;

  always_comb begin
    f_mode    = M_IDLE;
    f_emit    = 1'b0;
    f_ident   = 1'b0;
    f_res     = R_NORMAL;
    f_tok     = '{kind: K_INVALID, start: pos_r, len: COUNT_BITS'(1), line: line_r, col: col_r};
    unique case (b)
      8'h20, 8'h09, 8'h0D: f_emit = 1'b0;
      8'h00: begin
        f_emit = 1'b1; f_res = R_END;
        f_tok.kind = K_END; f_tok.len = '0; f_tok.col = sat_inc(col_r);
      end
      8'h0A: begin
        f_emit = 1'b1; f_res = R_NEWLINE;
        f_tok.kind = K_NEWLINE; f_tok.line = sat_inc(line_r); f_tok.col = '0;
      end
      8'h2E: f_mode = M_DOT;
      8'h3D: f_mode = M_EQ;
      8'h21: f_mode = M_BANG;
      8'h3C: f_mode = M_LT;
      8'h3E: f_mode = M_GT;
      8'h26: f_mode = M_AMP;
      8'h7C: f_mode = M_PIPE;
      8'h28: begin f_emit = 1'b1; f_tok.kind = K_LPAREN;  end
      8'h29: begin f_emit = 1'b1; f_tok.kind = K_RPAREN;  end
      8'h7B: begin f_emit = 1'b1; f_tok.kind = K_LBRACE;  end
      8'h7D: begin f_emit = 1'b1; f_tok.kind = K_RBRACE;  end
      8'h5B: begin f_emit = 1'b1; f_tok.kind = K_LBRACK;  end
      8'h5D: begin f_emit = 1'b1; f_tok.kind = K_RBRACK;  end
      8'h2C: begin f_emit = 1'b1; f_tok.kind = K_COMMA;   end
      8'h2B: begin f_emit = 1'b1; f_tok.kind = K_PLUS;    end
      8'h2D: begin f_emit = 1'b1; f_tok.kind = K_MINUS;   end
      8'h2A: begin f_emit = 1'b1; f_tok.kind = K_STAR;    end
      8'h2F: begin f_emit = 1'b1; f_tok.kind = K_SLASH;   end
      8'h25: begin f_emit = 1'b1; f_tok.kind = K_PERCENT; end
      default: begin
        if (is_alpha(b) || b == 8'h5F) begin
          f_mode = M_IDENT; f_ident = 1'b1;
        end else if (is_digit(b)) begin
          f_mode = M_NUM;
        end else begin
          f_emit = 1'b1;
        end
      end
    endcase
  end

  // lookahead state and token release
  logic                 p_emit, use_fresh, dd_emit;
  tok_t                 p_tok, dd_tok;
  logic [COUNT_BITS-1:0] len_p1;
  logic [OFFSET_BITS:0] dd_start_w;
  logic [COUNT_BITS:0]  dd_col_w;
  logic [7:0]           want;
  logic [KIND_BITS-1:0] kind2, kind1;

  assign len_p1     = sat_inc(tlen_r);
  assign dd_start_w = {1'b0, tstart_r} + (OFFSET_BITS + 1)'(tlen_r);
  assign dd_col_w   = {1'b0, tcol_r} + {1'b0, tlen_r};

  // pair operators: expected second byte and both kinds
  always_comb begin
    want = 8'h3D; kind2 = K_EQEQ; kind1 = K_EQ;
    unique case (mode_r)
      M_BANG:  begin kind2 = K_NE;     kind1 = K_BANG;    end
      M_LT:    begin kind2 = K_LE;     kind1 = K_LT;      end
      M_GT:    begin kind2 = K_GE;     kind1 = K_GT;      end
      M_AMP:   begin want = 8'h26; kind2 = K_ANDAND; kind1 = K_INVALID; end
      M_PIPE:  begin want = 8'h7C; kind2 = K_OROR;   kind1 = K_INVALID; end
      default: begin want = 8'h3D; kind2 = K_EQEQ;   kind1 = K_EQ;      end
    endcase
  end

  always_comb begin
    mode_nxt  = mode_r;
    tlen_nxt  = tlen_r;
    kw_nxt    = kw_r;
    p_emit    = 1'b0;
    dd_emit   = 1'b0;
    use_fresh = 1'b0;
    p_tok     = '{kind: K_INVALID, start: tstart_r, len: tlen_r, line: tline_r, col: tcol_r};
    dd_tok    = '{kind: K_DOTDOT,
                  start: dd_start_w[OFFSET_BITS] ? OFF_MAX : dd_start_w[OFFSET_BITS-1:0],
                  len: COUNT_BITS'(2), line: tline_r,
                  col: dd_col_w[COUNT_BITS] ? CNT_MAX : dd_col_w[COUNT_BITS-1:0]};
    unique case (mode_r)
      M_IDENT: begin
        if (is_ident_cont(b)) begin
          for (int i = 1; i < KW_BYTES; i++) begin
            if (tlen_r == COUNT_BITS'(i)) kw_nxt[8*i +: 8] = b;
          end
          tlen_nxt = len_p1;
        end else begin
          p_emit = 1'b1; p_tok.kind = ident_kind(kw_r, tlen_r); use_fresh = 1'b1;
        end
      end
      M_NUM: begin
        if (is_digit(b)) tlen_nxt = len_p1;
        else if (b == 8'h2E) mode_nxt = M_NUMDOT;
        else begin
          p_emit = 1'b1; p_tok.kind = K_NUMBER; use_fresh = 1'b1;
        end
      end
      M_NUMDOT: begin
        if (b == 8'h2E) begin
          p_emit = 1'b1; p_tok.kind = K_NUMBER; dd_emit = 1'b1; mode_nxt = M_IDLE;
        end else if (is_digit(b)) begin
          tlen_nxt = sat_inc(len_p1); mode_nxt = M_NUM;
        end else begin
          p_emit = 1'b1; p_tok.kind = K_NUMBER; p_tok.len = len_p1; use_fresh = 1'b1;
        end
      end
      M_DOT: begin
        if (is_digit(b)) begin
          tlen_nxt = COUNT_BITS'(2); mode_nxt = M_NUM;
        end else if (b == 8'h2E) begin
          p_emit = 1'b1; p_tok.kind = K_DOTDOT; p_tok.len = COUNT_BITS'(2);
          mode_nxt = M_IDLE;
        end else begin
          p_emit = 1'b1; p_tok.len = COUNT_BITS'(1); use_fresh = 1'b1;
        end
      end
      M_EQ, M_BANG, M_LT, M_GT, M_AMP, M_PIPE: begin
        p_emit = 1'b1;
        if (b == want) begin
          p_tok.kind = kind2; p_tok.len = COUNT_BITS'(2); mode_nxt = M_IDLE;
        end else begin
          p_tok.kind = kind1; p_tok.len = COUNT_BITS'(1); use_fresh = 1'b1;
        end
      end
      default: use_fresh = 1'b1;
    endcase
    if (use_fresh) begin
      mode_nxt = f_mode;
      tlen_nxt = COUNT_BITS'(1);
      if (f_ident) kw_nxt = {{(8*KW_BYTES-8){1'b0}}, b};
    end
  end

  // counters and token origin
  res_t res;
  assign res = use_fresh ? f_res : R_NORMAL;

  always_comb begin
    pos_nxt    = (&pos_r) ? pos_r : pos_r + 1'b1;
    line_nxt   = line_r;
    col_nxt    = sat_inc(col_r);
    tstart_nxt = use_fresh ? pos_r  : tstart_r;
    tline_nxt  = use_fresh ? line_r : tline_r;
    tcol_nxt   = use_fresh ? col_r  : tcol_r;
    if (res == R_NEWLINE) begin
      line_nxt = sat_inc(line_r);
      col_nxt  = COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      pos_r    <= '0;
      line_r   <= COUNT_BITS'(1);
      col_r    <= COUNT_BITS'(1);
      tstart_r <= '0;
      tlen_r   <= '0;
      tline_r  <= COUNT_BITS'(1);
      tcol_r   <= COUNT_BITS'(1);
      kw_r     <= '0;
    end else if (acc) begin
      if (res == R_END) begin
        mode_r   <= M_IDLE;
        pos_r    <= '0;
        line_r   <= COUNT_BITS'(1);
        col_r    <= COUNT_BITS'(1);
        tstart_r <= '0;
        tlen_r   <= '0;
        tline_r  <= COUNT_BITS'(1);
        tcol_r   <= COUNT_BITS'(1);
        kw_r     <= '0;
      end else begin
        mode_r   <= mode_nxt;
        pos_r    <= pos_nxt;
        line_r   <= line_nxt;
        col_r    <= col_nxt;
        tstart_r <= tstart_nxt;
        tlen_r   <= tlen_nxt;
        tline_r  <= tline_nxt;
        tcol_r   <= tcol_nxt;
        kw_r     <= kw_nxt;
      end
    end
  end

  // pick up to two tokens for the queue
  logic  fr_emit, w0_en, w1_en;
  qent_t w0, w1;

  assign fr_emit = use_fresh && f_emit;

  always_comb begin
    w0_en = 1'b0;
    w1_en = 1'b0;
    w0    = '{tok: p_tok, last: 1'b1};
    w1    = '{tok: f_tok, last: 1'b1};
    if (p_emit) begin
      w0_en = acc;
      if (dd_emit) begin
        w0.last = 1'b0; w1.tok = dd_tok; w1_en = acc;
      end else if (fr_emit) begin
        w0.last = 1'b0; w1_en = acc;
      end
    end else if (fr_emit) begin
      w0.tok = f_tok; w0_en = acc;
    end
  end

  sst_token_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr0_en (w0_en),
    .wr0    (w0),
    .wr1_en (w1_en),
    .wr1    (w1),
    .rd_en  (out_tvalid && out_tready),
    .rd     (q_rd),
    .stat   (qstat)
  );

  assign in_tready  = qstat.room;
  assign out_tvalid = qstat.count != '0;
  assign out_tdata  = {2'b00, q_rd.tok.col, q_rd.tok.line, q_rd.tok.len,
                       q_rd.tok.start, q_rd.tok.kind};
  assign out_tlast  = q_rd.last;

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("token queue overfilled");

  // a second token is only ever written behind a first
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    w1_en |-> w0_en && !w0.last)
    else $error("second token without first");

  // end of source restores counters
  a_end_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_tdata == 8'h00 && (mode_r == M_IDLE || mode_r == M_IDENT))
      |=> pos_r == '0 && line_r == COUNT_BITS'(1) && col_r == COUNT_BITS'(1)
          && mode_r == M_IDLE)
    else $error("counters not restored after end token");

  // a byte is only taken with room for two tokens
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> qstat.count <= QCNT_BITS'(QUEUE_DEPTH - 2))
    else $error("byte taken without room");

endmodule

### hdl/sst_token_queue.sv
module sst_token_queue
  import sst_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr0_en,
  input  qent_t  wr0,
  input  logic   wr1_en,
  input  qent_t  wr1,
  input  logic   rd_en,
  output qent_t  rd,
  output qstat_t stat
);

  qent_t                mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [QPTR_BITS-1:0] wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_BITS'(wr0_en) + QPTR_BITS'(wr1_en);
    rd_ptr_nxt = rd_ptr_r + QPTR_BITS'(rd_en);
    cnt_nxt    = cnt_r + QCNT_BITS'(wr0_en) + QCNT_BITS'(wr1_en) - QCNT_BITS'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage, second item lands behind the first
  always_ff @(posedge clk) begin
    if (wr0_en) mem[wr_ptr_r] <= wr0;
    if (wr1_en) mem[wr_ptr_p1] <= wr1;
  end

  assign rd         = mem[rd_ptr_r];
  assign stat.count = cnt_r;
  assign stat.room  = cnt_r <= QCNT_BITS'(QUEUE_DEPTH - 2);

endmodule
